// ===== rtl/core/ile_pkg.sv =====
// ----------------------------------------------------------------------------
// ile_pkg
// Shared widths and codes for the indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

    localparam int CMD_W  = 3;
    localparam int POS_W  = 8;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 7;

    // command codes
    localparam logic [CMD_W-1:0] CMD_READ = 3'd0;
    localparam logic [CMD_W-1:0] CMD_HEAD = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TAIL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_AT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL  = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

endpackage

// ===== rtl/core/ile_store.sv =====
// ----------------------------------------------------------------------------
// ile_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ile_store #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [IDX_W-1:0]          waddr,
    input  logic [ile_pkg::VAL_W-1:0] wdata,
    input  logic                      re,
    input  logic [IDX_W-1:0]          raddr,
    output logic [ile_pkg::VAL_W-1:0] rdata
);
    import ile_pkg::*;

    logic [VAL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/ile_seq.sv =====
// ----------------------------------------------------------------------------
// ile_seq
// Command sequencer: decodes a transaction, moves entries one at a time
// through the memory port and registers the response.
// ----------------------------------------------------------------------------
module ile_seq #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6,
    parameter int CNT_W = 7
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  logic [ile_pkg::CMD_W-1:0]         cmd,
    input  logic signed [ile_pkg::POS_W-1:0]  position,
    input  logic signed [ile_pkg::VAL_W-1:0]  item_value,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic signed [ile_pkg::VAL_W-1:0]  read_value,
    output logic [ile_pkg::STAT_W-1:0]        status,
    output logic [ile_pkg::LEN_W-1:0]         list_length,
    output logic                              mem_we,
    output logic [IDX_W-1:0]                  mem_waddr,
    output logic [ile_pkg::VAL_W-1:0]         mem_wdata,
    output logic                              mem_re,
    output logic [IDX_W-1:0]                  mem_raddr,
    input  logic [ile_pkg::VAL_W-1:0]         mem_rdata
);
    import ile_pkg::*;

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_RD_DATA,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_DEL_RD,
        S_DEL_WR,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [VAL_W-1:0]    val_reg, val_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    ptr_reg, ptr_next;
    logic [CNT_W-1:0]    target_reg, target_next;
    logic [VAL_W-1:0]    res_val_reg, res_val_next;
    logic [STAT_W-1:0]   res_st_reg, res_st_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [VAL_W-1:0]    rsp_val_reg, rsp_val_next;
    logic [STAT_W-1:0]   rsp_st_reg, rsp_st_next;
    logic [LEN_W-1:0]    rsp_len_reg, rsp_len_next;

    logic                pos_neg;
    logic [CMP_W-1:0]    pos_u;
    logic [CMP_W-1:0]    count_u;
    logic                range_bad;
    logic                past_end;
    logic                full;
    logic [CNT_W-1:0]    ptr_dec;
    logic [CNT_W-1:0]    ptr_inc;

    assign pos_neg   = pos_reg[POS_W-1];
    assign pos_u     = CMP_W'(pos_reg[POS_W-2:0]);
    assign count_u   = CMP_W'(count_reg);
    assign range_bad = pos_neg || (pos_u >= count_u);
    assign past_end  = !pos_neg && (pos_u > count_u);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign ptr_dec   = ptr_reg - CNT_W'(1);
    assign ptr_inc   = ptr_reg + CNT_W'(1);

    assign cmd_ready   = (state_reg == S_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign read_value  = rsp_val_reg;
    assign status      = rsp_st_reg;
    assign list_length = rsp_len_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        target_next    = target_reg;
        res_val_next   = res_val_reg;
        res_st_next    = res_st_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_val_next   = rsp_val_reg;
        rsp_st_next    = rsp_st_reg;
        rsp_len_next   = rsp_len_reg;
        mem_we         = 1'b0;
        mem_waddr      = ptr_reg[IDX_W-1:0];
        mem_wdata      = mem_rdata;
        mem_re         = 1'b0;
        mem_raddr      = ptr_dec[IDX_W-1:0];

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next     = cmd;
                    pos_next     = position;
                    val_next     = item_value;
                    res_val_next = '0;
                    res_st_next  = ST_DONE;
                    state_next   = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                ptr_next = count_reg;
                case (cmd_reg)
                    CMD_READ:
                    begin
                        if (range_bad)
                        begin
                            res_val_next = '1;
                            res_st_next  = ST_RANGE;
                            state_next   = S_FINISH;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = IDX_W'(pos_u);
                            state_next = S_RD_DATA;
                        end
                    end
                    CMD_HEAD:
                    begin
                        if (full)
                        begin
                            res_st_next = ST_FULL;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            target_next = '0;
                            state_next  = S_INS_RD;
                        end
                    end
                    CMD_TAIL:
                    begin
                        if (full)
                        begin
                            res_st_next = ST_FULL;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            target_next = count_reg;
                            state_next  = S_INS_RD;
                        end
                    end
                    CMD_AT:
                    begin
                        // past-the-end check takes priority over full
                        if (past_end)
                        begin
                            res_st_next = ST_RANGE;
                            state_next  = S_FINISH;
                        end
                        else if (full)
                        begin
                            res_st_next = ST_FULL;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            target_next = pos_neg ? '0 : CNT_W'(pos_u);
                            state_next  = S_INS_RD;
                        end
                    end
                    CMD_DEL:
                    begin
                        if (range_bad)
                        begin
                            res_st_next = ST_RANGE;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            ptr_next   = CNT_W'(pos_u);
                            state_next = S_DEL_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_RD_DATA:
            begin
                res_val_next = mem_rdata;
                state_next   = S_FINISH;
            end
            // insert: walk down from the tail, copying each entry up by one
            S_INS_RD:
            begin
                if (ptr_reg == target_reg)
                begin
                    state_next = S_INS_PUT;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ptr_dec[IDX_W-1:0];
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ptr_reg[IDX_W-1:0];
                mem_wdata  = mem_rdata;
                ptr_next   = ptr_dec;
                state_next = S_INS_RD;
            end
            S_INS_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = target_reg[IDX_W-1:0];
                mem_wdata  = val_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = S_FINISH;
            end
            // delete: walk up from the gap, copying each entry down by one
            S_DEL_RD:
            begin
                if (ptr_inc >= count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_FINISH;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ptr_inc[IDX_W-1:0];
                    state_next = S_DEL_WR;
                end
            end
            S_DEL_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ptr_reg[IDX_W-1:0];
                mem_wdata  = mem_rdata;
                ptr_next   = ptr_inc;
                state_next = S_DEL_RD;
            end
            S_FINISH:
            begin
                // hold until the response register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_val_next   = res_val_reg;
                    rsp_st_next    = res_st_reg;
                    rsp_len_next   = LEN_W'(count_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            cmd_reg       <= '0;
            pos_reg       <= '0;
            val_reg       <= '0;
            ptr_reg       <= '0;
            target_reg    <= '0;
            res_val_reg   <= '0;
            res_st_reg    <= ST_DONE;
            rsp_val_reg   <= '0;
            rsp_st_reg    <= ST_DONE;
            rsp_len_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            cmd_reg       <= cmd_next;
            pos_reg       <= pos_next;
            val_reg       <= val_next;
            ptr_reg       <= ptr_next;
            target_reg    <= target_next;
            res_val_reg   <= res_val_next;
            res_st_reg    <= res_st_next;
            rsp_val_reg   <= rsp_val_next;
            rsp_st_reg    <= rsp_st_next;
            rsp_len_reg   <= rsp_len_next;
        end
    end

endmodule

// ===== rtl/core/indexed_list_engine.sv =====
// Ordered list of up to DEPTH signed 32-bit entries held in a single-port-pair
// memory. A command transaction is taken only while the engine is idle and
// yields one response. Insert and delete move every entry between the index
// and the tail, one entry per read/write pair (head inserts at index 0, tail
// at the length). The last state waits while the previous response has not
// yet been taken.
// The response is registered, so a new command is accepted while the previous
// response still waits to be taken.
// ----------------------------------------------------------------------------
// indexed_list_engine
// Top level: command sequencer plus entry memory.
// ----------------------------------------------------------------------------
module indexed_list_engine #(
    parameter int DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  logic [ile_pkg::CMD_W-1:0]         cmd,
    input  logic signed [ile_pkg::POS_W-1:0]  position,
    input  logic signed [ile_pkg::VAL_W-1:0]  item_value,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic signed [ile_pkg::VAL_W-1:0]  read_value,
    output logic [ile_pkg::STAT_W-1:0]        status,
    output logic [ile_pkg::LEN_W-1:0]         list_length
);
    import ile_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [VAL_W-1:0]   mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    logic [VAL_W-1:0]   mem_rdata;

    ile_seq #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .position    (position),
        .item_value  (item_value),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .read_value  (read_value),
        .status      (status),
        .list_length (list_length),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    ile_store #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// ===== tb/list_shadow_checker.sv =====
// ----------------------------------------------------------------------------
// list_shadow_checker
// Watches both channels of the indexed list engine. Keeps a shadow copy of
// the list, works out the response to every accepted command transaction and
// compares each response transaction, field by field, with the oldest one
// still owed.
// ----------------------------------------------------------------------------
module list_shadow_checker
    import ile_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    input  logic                     cmd_ready,
    input  logic [CMD_W-1:0]         cmd,
    input  logic signed [POS_W-1:0]  position,
    input  logic signed [VAL_W-1:0]  item_value,
    input  logic                     rsp_valid,
    input  logic                     rsp_ready,
    input  logic signed [VAL_W-1:0]  read_value,
    input  logic [STAT_W-1:0]        status,
    input  logic [LEN_W-1:0]         list_length,
    output int unsigned              mismatch_count,
    output int unsigned              responses_owed,
    output int unsigned              shadow_length
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [VAL_W-1:0] read_value;
        logic [STAT_W-1:0]       status;
        logic [LEN_W-1:0]        list_length;
    } list_response_t;

    logic signed [VAL_W-1:0] shadow_list[$];
    list_response_t          owed_responses[$];
    list_response_t          want;
    int unsigned             faults = 0;

    // Applies one command to the shadow list and returns the response it owes
    function automatic list_response_t apply_list_command(
        input logic [CMD_W-1:0]        op,
        input logic signed [POS_W-1:0] pos,
        input logic signed [VAL_W-1:0] value
    );
        list_response_t r;
        int             len;
        int             idx;
        bit             full;
        len  = shadow_list.size();
        idx  = pos;
        full = (len >= DEPTH);
        r.read_value = '0;
        r.status     = ST_DONE;
        case (op)
            CMD_READ:
                if (idx < 0 || idx >= len)
                begin
                    r.read_value = '1;
                    r.status     = ST_RANGE;
                end
                else
                begin
                    r.read_value = shadow_list[idx];
                end
            CMD_HEAD:
                if (full)
                    r.status = ST_FULL;
                else
                    shadow_list.push_front(value);
            CMD_TAIL:
                if (full)
                    r.status = ST_FULL;
                else
                    shadow_list.push_back(value);
            CMD_AT:
                // range check wins over the full check; negative index goes to head
                if (idx > len)
                    r.status = ST_RANGE;
                else if (full)
                    r.status = ST_FULL;
                else
                    shadow_list.insert(idx < 0 ? 0 : idx, value);
            CMD_DEL:
                if (idx < 0 || idx >= len)
                    r.status = ST_RANGE;
                else
                    shadow_list.delete(idx);
            default:
                ;
        endcase
        r.list_length = LEN_W'(shadow_list.size());
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_list.delete();
            owed_responses.delete();
            faults = 0;
            mismatch_count <= 0;
            responses_owed <= 0;
            shadow_length  <= 0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
                owed_responses.push_back(apply_list_command(cmd, position, item_value));
            if (rsp_valid && rsp_ready)
            begin
                if (owed_responses.size() == 0)
                begin
                    faults++;
                    $error("unexpected response: read_value %0d status %0d list_length %0d",
                           read_value, status, list_length);
                end
                else
                begin
                    want = owed_responses.pop_front();
                    if (read_value !== want.read_value)
                    begin
                        faults++;
                        $error("read_value mismatch: expected %0d, actual %0d",
                               want.read_value, read_value);
                    end
                    if (status !== want.status)
                    begin
                        faults++;
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, status);
                    end
                    if (list_length !== want.list_length)
                    begin
                        faults++;
                        $error("list_length mismatch: expected %0d, actual %0d",
                               want.list_length, list_length);
                    end
                end
            end
            mismatch_count <= faults;
            responses_owed <= owed_responses.size();
            shadow_length  <= shadow_list.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives command transactions into the indexed list engine: a short directed
// set covering the index edge cases, then random traffic that fills the list
// to capacity and drains it again, under three sender/receiver idle mixes.
// Checking is done by list_shadow_checker; this module only gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ile_pkg::*;

    localparam int DEPTH            = 64;
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int RANDOM_PER_PHASE = 250;
    localparam int DRAIN_CYCLES     = 200;

    logic                    clk        = 1'b0;
    logic                    rst_n      = 1'b0;
    logic                    cmd_valid  = 1'b0;
    logic [CMD_W-1:0]        cmd        = '0;
    logic signed [POS_W-1:0] position   = '0;
    logic signed [VAL_W-1:0] item_value = '0;
    logic                    rsp_ready  = 1'b0;
    logic                    cmd_ready;
    logic                    rsp_valid;
    logic signed [VAL_W-1:0] read_value;
    logic [STAT_W-1:0]       status;
    logic [LEN_W-1:0]        list_length;

    int unsigned mismatch_count;
    int unsigned responses_owed;
    int unsigned shadow_length;
    int unsigned cycle_count   = 0;
    int          send_idle_pct = 0;
    int          rsp_idle_pct  = 0;
    bit          filling       = 1'b1;

    always #4 clk = ~clk;

    indexed_list_engine #(
        .DEPTH (DEPTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .position    (position),
        .item_value  (item_value),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .read_value  (read_value),
        .status      (status),
        .list_length (list_length)
    );

    list_shadow_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd),
        .position       (position),
        .item_value     (item_value),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .read_value     (read_value),
        .status         (status),
        .list_length    (list_length),
        .mismatch_count (mismatch_count),
        .responses_owed (responses_owed),
        .shadow_length  (shadow_length)
    );

    always @(posedge clk)
        rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Returns at the edge where the transaction is taken; valid stays high
    task automatic send_command(
        input logic [CMD_W-1:0]        op,
        input logic signed [POS_W-1:0] pos,
        input logic signed [VAL_W-1:0] value
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid  <= 1'b1;
        cmd        <= op;
        position   <= pos;
        item_value <= value;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (responses_owed != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [POS_W-1:0] pick_position(input int len);
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return POS_W'($urandom_range(len));
        if (roll < 85)
        begin
            case ($urandom_range(3))
                0:       return '1;
                1:       return '0;
                2:       return POS_W'(len + 1);
                default: return POS_W'(len - 1);
            endcase
        end
        return POS_W'($urandom());
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        if ($urandom_range(99) < 80)
            return VAL_W'($urandom());
        case ($urandom_range(3))
            0:       return {1'b0, {(VAL_W-1){1'b1}}};
            1:       return {1'b1, {(VAL_W-1){1'b0}}};
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // Alternates between filling to capacity and draining to empty
    task automatic send_random_item();
        int               len;
        int               roll;
        int               ins_pct;
        int               del_pct;
        logic [CMD_W-1:0] op;
        len = shadow_length;
        if (len >= DEPTH && $urandom_range(3) == 0)
            filling = 1'b0;
        else if (len == 0)
            filling = 1'b1;
        ins_pct = filling ? 70 : 15;
        del_pct = filling ? 15 : 65;
        roll    = $urandom_range(99);
        if (roll < ins_pct)
        begin
            case ($urandom_range(2))
                0:       op = CMD_HEAD;
                1:       op = CMD_TAIL;
                default: op = CMD_AT;
            endcase
        end
        else if (roll < ins_pct + del_pct)
            op = CMD_DEL;
        else if (roll < 97)
            op = CMD_READ;
        else
            op = CMD_W'($urandom_range(2**CMD_W - 1, CMD_DEL + 1));
        send_command(op, pick_position(len), pick_value());
    endtask

    initial
    begin
        send_idle_pct = 32;
        rsp_idle_pct <= 52;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: every indexed access is out of range
        send_command(CMD_READ, '0, '0);
        send_command(CMD_DEL, '0, '0);
        send_command(CMD_AT, 8'sd1, 32'sd7);
        // negative index lands at the head
        send_command(CMD_AT, -8'sd128, 32'sh7FFFFFFF);
        send_command(CMD_HEAD, '0, 32'sh80000000);
        send_command(CMD_TAIL, 8'sd127, '0);
        send_command(CMD_AT, 8'sd3, '1);
        send_command(CMD_AT, 8'sd2, 32'sh5A5A5A5A);
        send_command(CMD_AT, 8'sd127, 32'sh0F0F0F0F);
        send_command(CMD_READ, '0, '1);
        send_command(CMD_READ, 8'sd4, '0);
        send_command(CMD_READ, 8'sd5, '0);
        send_command(CMD_READ, '1, '0);
        send_command(CMD_READ, 8'sd127, 32'sh12345678);
        for (int op = CMD_DEL + 1; op < 2**CMD_W; op++)
            send_command(CMD_W'(op), pick_position(0), pick_value());
        send_command(CMD_DEL, 8'sd2, '1);
        send_command(CMD_DEL, 8'sd4, '0);
        send_command(CMD_DEL, -8'sd128, '0);
        send_command(CMD_DEL, '0, '0);
        send_command(CMD_DEL, 8'sd2, '0);
        send_command(CMD_READ, 8'sd1, '0);
        wait_drained();

        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            send_random_item();
        wait_drained();

        send_idle_pct = 52;
        rsp_idle_pct <= 32;
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            send_random_item();
        wait_drained();

        send_idle_pct = 0;
        rsp_idle_pct <= 0;
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            send_random_item();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && responses_owed == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
